### rtl/ackermann_wheel_speed_kinematics_core_assert.svh
// Assertion macros shared by the kinematics core modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ACKERMANN_WHEEL_SPEED_KINEMATICS_CORE_ASSERT_SVH
`define ACKERMANN_WHEEL_SPEED_KINEMATICS_CORE_ASSERT_SVH

// Condition in this cycle implies the consequence in the same cycle.
`define AWSK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition in this cycle implies the consequence in the next cycle.
`define AWSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/awsk_pkg.sv
// ----------------------------------------------------------------------------
// awsk_pkg
// Types, constants and the arctangent table of the wheel speed kinematics core.
// ----------------------------------------------------------------------------
package awsk_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [15:0] TRACK_RST  = 16'd1229;
  localparam logic [15:0] IRAD_RST   = 16'd5120;
  localparam logic [15:0] WBASE_RST  = 16'd1024;
  localparam logic [11:0] THRESH_RST = 12'd1;

  localparam logic signed [16:0] ANGLE_LIMIT = 17'sd25736;
  localparam logic signed [29:0] SPEED_MAX   = 30'sd8388607;
  localparam logic signed [29:0] SPEED_MIN   = -30'sd8388608;

  typedef enum logic [1:0] {
    REG_TRACK  = 2'd0,
    REG_IRAD   = 2'd1,
    REG_WBASE  = 2'd2,
    REG_THRESH = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_wheel_speed;
    logic signed [23:0] right_wheel_speed;
    logic signed [15:0] steering_angle;
    logic               command_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rear_track;
    logic [15:0] inverse_wheel_radius;
    logic [15:0] wheelbase_length;
    logic [11:0] near_zero_threshold;
  } cfg_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic               zero;
    logic               cmd_ok;
  } cmd_t;

  // One CORDIC pipeline stage, wheel speeds ride along.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic signed [23:0] wl;
    logic signed [23:0] wr;
    logic               zero;
    logic               cmd_ok;
  } cstage_t;

  // atan(2^-i) in Q2.30, rounded to nearest.
  function automatic logic signed [32:0] atan_q30(input int i);
    logic signed [32:0] r;
    unique case (i)
      0:  r = 33'sd843314857;
      1:  r = 33'sd497837829;
      2:  r = 33'sd263043837;
      3:  r = 33'sd133525159;
      4:  r = 33'sd67021687;
      5:  r = 33'sd33543516;
      6:  r = 33'sd16775851;
      7:  r = 33'sd8388437;
      8:  r = 33'sd4194283;
      9:  r = 33'sd2097149;
      10: r = 33'sd1048576;
      11: r = 33'sd524288;
      12: r = 33'sd262144;
      13: r = 33'sd131072;
      14: r = 33'sd65536;
      15: r = 33'sd32768;
      16: r = 33'sd16384;
      17: r = 33'sd8192;
      18: r = 33'sd4096;
      19: r = 33'sd2048;
      20: r = 33'sd1024;
      21: r = 33'sd512;
      22: r = 33'sd256;
      23: r = 33'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/ackermann_wheel_speed_kinematics_core.sv
// ----------------------------------------------------------------------------
// ackermann_wheel_speed_kinematics_core
// Inverse bicycle-model kinematics: wheel speeds and steering angle.
// ----------------------------------------------------------------------------
// Takes one command per clock while in_stall_o is low and returns one result
// per command in order. A command passes through the input register, the
// queue, stages 0 and 1, the CORDIC stages and the output register. A
// two-entry queue sits between the input stage and the arithmetic pipeline,
// which stalls as a whole while its output register waits. Write the
// geometry registers only while no command is in flight.
module ackermann_wheel_speed_kinematics_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  awsk_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output awsk_pkg::out_item_t out_data_o
);

  awsk_pkg::cfg_t cfg_q;
  logic           push, full, pop, empty;
  awsk_pkg::cmd_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rear_track           <= awsk_pkg::TRACK_RST;
      cfg_q.inverse_wheel_radius <= awsk_pkg::IRAD_RST;
      cfg_q.wheelbase_length     <= awsk_pkg::WBASE_RST;
      cfg_q.near_zero_threshold  <= awsk_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (awsk_pkg::reg_idx_e'(cfg_idx_i))
        awsk_pkg::REG_TRACK:  cfg_q.rear_track           <= cfg_data_i;
        awsk_pkg::REG_IRAD:   cfg_q.inverse_wheel_radius <= cfg_data_i;
        awsk_pkg::REG_WBASE:  cfg_q.wheelbase_length     <= cfg_data_i;
        awsk_pkg::REG_THRESH: cfg_q.near_zero_threshold  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  awsk_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .thresh_i    (cfg_q.near_zero_threshold),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  awsk_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  awsk_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

### rtl/awsk_front.sv
// ----------------------------------------------------------------------------
// awsk_front
// Accepts commands and flags those whose speed is below the zero threshold.
// ----------------------------------------------------------------------------
module awsk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  awsk_pkg::in_item_t  in_data_i,
  input  logic [11:0]         thresh_i,
  output logic                push_o,
  output awsk_pkg::cmd_t      push_data_o,
  input  logic                full_i
);

  logic            vld_q, vld_d;
  awsk_pkg::cmd_t  cmd_q, cmd_d;
  logic            accept;
  logic [16:0]     av, aw;

  assign push_o      = vld_q && !full_i;
  assign in_stall_o  = vld_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = cmd_q;

  always_comb begin
    av = in_data_i.linear_velocity[15] ? 17'(-$signed({in_data_i.linear_velocity[15],
                                                       in_data_i.linear_velocity}))
                                       : {1'b0, in_data_i.linear_velocity};
    aw = in_data_i.angular_velocity[15] ? 17'(-$signed({in_data_i.angular_velocity[15],
                                                        in_data_i.angular_velocity}))
                                        : {1'b0, in_data_i.angular_velocity};
    cmd_d.v      = in_data_i.linear_velocity;
    cmd_d.w      = in_data_i.angular_velocity;
    cmd_d.zero   = av < {5'd0, thresh_i};
    // a spin-in-place command is rejected
    cmd_d.cmd_ok = !(cmd_d.zero && (aw >= {5'd0, thresh_i}));
    vld_d        = accept ? 1'b1 : (push_o ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

### rtl/awsk_queue.sv
// ----------------------------------------------------------------------------
// awsk_queue
// Short FIFO between the front and the back of the core.
// ----------------------------------------------------------------------------
`include "ackermann_wheel_speed_kinematics_core_assert.svh"

module awsk_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  awsk_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output awsk_pkg::cmd_t  pop_data_o,
  output logic            empty_o
);

  localparam int PtrW = $clog2(awsk_pkg::QUEUE_DEPTH);

  awsk_pkg::cmd_t  mem_q [awsk_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o     = cnt_q == (PtrW+1)'(awsk_pkg::QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(awsk_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(awsk_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `AWSK_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "push into full queue")
  `AWSK_ASSERT_IMPL(a_no_underflow, pop_i, !empty_o, "pop from empty queue")
  `AWSK_ASSERT_NEXT(a_push_only_fills, push_i && !pop_i, !empty_o,
                    "queue empty after a push")

endmodule

### rtl/awsk_back.sv
// ----------------------------------------------------------------------------
// awsk_back
// Wheel speed multipliers and pipelined vectoring CORDIC for the steering angle.
// ----------------------------------------------------------------------------
`include "ackermann_wheel_speed_kinematics_core_assert.svh"

module awsk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  awsk_pkg::cfg_t      cfg_i,
  input  logic                empty_i,
  input  awsk_pkg::cmd_t      pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output awsk_pkg::out_item_t out_data_o
);

  localparam int N = awsk_pkg::CORDIC_STAGES;

  logic en;

  // stage 0: products with the geometry registers
  logic               s0_vld_q;
  logic signed [15:0] s0_v_q;
  logic signed [32:0] s0_diff_q;
  logic signed [33:0] s0_y_q;
  logic               s0_zero_q, s0_ok_q;

  // stage 1: wheel products and CORDIC start vector
  logic               s1_vld_q;
  logic signed [50:0] s1_pl_q, s1_pr_q;
  logic signed [33:0] s1_x_q, s1_y_q;
  logic               s1_zero_q, s1_ok_q;

  logic signed [33:0] base, lin_l, lin_r, x0;

  awsk_pkg::cstage_t c_q [N+1];
  logic [N:0]        c_vld_q;

  logic                out_vld_q;
  awsk_pkg::out_item_t out_q, out_d;

  assign en          = !out_vld_q || !out_stall_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign base  = {{5{s0_v_q[15]}}, s0_v_q, 13'd0};
  assign lin_l = base - {s0_diff_q[32], s0_diff_q};
  assign lin_r = base + {s0_diff_q[32], s0_diff_q};
  assign x0    = {{6{s0_v_q[15]}}, s0_v_q, 12'd0};

  function automatic logic signed [23:0] sat_round(input logic signed [50:0] p);
    logic signed [50:0] t;
    logic signed [29:0] r;
    t = p + 51'sd1048576;
    r = 30'(t >>> 21);
    if (r > awsk_pkg::SPEED_MAX) begin
      r = awsk_pkg::SPEED_MAX;
    end else if (r < awsk_pkg::SPEED_MIN) begin
      r = awsk_pkg::SPEED_MIN;
    end
    return r[23:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      c_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= pop_o;
      s1_vld_q  <= s0_vld_q;
      c_vld_q   <= {c_vld_q[N-1:0], s1_vld_q};
      out_vld_q <= c_vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_v_q    <= pop_data_i.v;
      s0_diff_q <= 33'(pop_data_i.w) * 33'($signed({1'b0, cfg_i.rear_track}));
      s0_y_q    <= 34'($signed({1'b0, cfg_i.wheelbase_length})) * 34'(pop_data_i.w);
      s0_zero_q <= pop_data_i.zero;
      s0_ok_q   <= pop_data_i.cmd_ok;

      s1_pl_q   <= 51'(lin_l) * 51'($signed({1'b0, cfg_i.inverse_wheel_radius}));
      s1_pr_q   <= 51'(lin_r) * 51'($signed({1'b0, cfg_i.inverse_wheel_radius}));
      // mirror into the right half plane for reversing
      s1_x_q    <= s0_v_q[15] ? -x0 : x0;
      s1_y_q    <= s0_v_q[15] ? -s0_y_q : s0_y_q;
      s1_zero_q <= s0_zero_q;
      s1_ok_q   <= s0_ok_q;

      c_q[0].x      <= s1_x_q;
      c_q[0].y      <= s1_y_q;
      c_q[0].z      <= '0;
      c_q[0].wl     <= sat_round(s1_pl_q);
      c_q[0].wr     <= sat_round(s1_pr_q);
      c_q[0].zero   <= s1_zero_q;
      c_q[0].cmd_ok <= s1_ok_q;

      out_q <= out_d;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    awsk_pkg::cstage_t nxt;
    always_comb begin
      nxt = c_q[k];
      if (c_q[k].y > 0) begin
        nxt.x = c_q[k].x + (c_q[k].y >>> k);
        nxt.y = c_q[k].y - (c_q[k].x >>> k);
        nxt.z = c_q[k].z + awsk_pkg::atan_q30(k);
      end else if (c_q[k].y < 0) begin
        nxt.x = c_q[k].x - (c_q[k].y >>> k);
        nxt.y = c_q[k].y + (c_q[k].x >>> k);
        nxt.z = c_q[k].z - awsk_pkg::atan_q30(k);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    logic signed [32:0] zt;
    logic signed [16:0] zr;
    zt = c_q[N].z + 33'sd32768;
    zr = 17'(zt >>> 16);
    if (zr > awsk_pkg::ANGLE_LIMIT) begin
      zr = awsk_pkg::ANGLE_LIMIT;
    end else if (zr < -awsk_pkg::ANGLE_LIMIT) begin
      zr = -awsk_pkg::ANGLE_LIMIT;
    end
    out_d.left_wheel_speed  = c_q[N].zero ? '0 : c_q[N].wl;
    out_d.right_wheel_speed = c_q[N].zero ? '0 : c_q[N].wr;
    out_d.steering_angle    = c_q[N].zero ? '0 : zr[15:0];
    out_d.command_valid     = c_q[N].cmd_ok;
  end

  `AWSK_ASSERT_IMPL(a_reject_zero, out_vld_q && !out_q.command_valid,
                    out_q.left_wheel_speed == '0 && out_q.right_wheel_speed == '0 &&
                    out_q.steering_angle == '0, "rejected command has nonzero outputs")
  `AWSK_ASSERT_IMPL(a_angle_range, out_vld_q,
                    $signed(out_q.steering_angle) <= 16'sd25736 &&
                    $signed(out_q.steering_angle) >= -16'sd25736, "angle out of range")
  `AWSK_ASSERT_NEXT(a_hold_stall, out_vld_q && out_stall_i,
                    out_vld_q && $stable(out_q), "stalled result changed")

endmodule
